FILE: src/segment_resequencer_macros.svh
// Assertion helpers used by the resequencer back side (srsq_back).
`ifndef SEGMENT_RESEQUENCER_MACROS_SVH
`define SEGMENT_RESEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/srsq_pkg.sv
package srsq_pkg;

    localparam int WINDOW_DEF  = 64;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [31:0] seq_num;
        logic [15:0] payload_handle;
        logic [13:0] payload_len;
        logic [9:0]  conn_id;
    } t_seg;

    typedef struct packed {
        logic [9:0]  out_conn;
        logic [31:0] out_seq;
        logic [15:0] out_handle;
        logic [13:0] out_len;
        logic        status;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [15:0] handle;
        logic [13:0] len;
    } t_slot;

    typedef enum logic [1:0] {
        K_STALE,
        K_AHEAD,
        K_BEYOND,
        K_INORDER
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_seg  seg;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

endpackage

FILE: src/srsq_ram.sv
module srsq_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/srsq_front.sv
module srsq_front #(
    parameter int WINDOW = srsq_pkg::WINDOW_DEF,
    localparam int SLOT_W = $clog2(WINDOW)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  srsq_pkg::t_seg      i_seg,
    output logic                o_busy,
    input  logic                i_pop,
    input  logic [31:0]         i_next_exp,
    input  logic [SLOT_W-1:0]   i_exp_slot,
    output logic                o_head_valid,
    output srsq_pkg::t_cmd      o_head,
    output logic [SLOT_W-1:0]   o_head_slot
);

    localparam logic [SLOT_W:0] WIN_V = (SLOT_W + 1)'(WINDOW);

    srsq_pkg::t_seg r_q [srsq_pkg::QDEPTH];
    logic [srsq_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [srsq_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [srsq_pkg::QCNT_W-1:0] r_count, n_count;

    logic           w_push;
    logic           w_pop;
    srsq_pkg::t_seg w_head;
    logic [31:0]    w_dist;
    logic [SLOT_W:0] w_sum;

    assign o_busy       = (r_count == srsq_pkg::QCNT_W'(srsq_pkg::QDEPTH));
    assign w_push       = i_start && !o_busy;
    assign o_head_valid = (r_count != '0);
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == srsq_pkg::QPTR_W'(srsq_pkg::QDEPTH - 1))
                     ? '0 : r_wr_ptr + srsq_pkg::QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == srsq_pkg::QPTR_W'(srsq_pkg::QDEPTH - 1))
                     ? '0 : r_rd_ptr + srsq_pkg::QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + srsq_pkg::QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - srsq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_seg;
        end
    end

    // Classify the head against the back's current expected number.
    assign w_head = r_q[r_rd_ptr];
    assign w_dist = w_head.seq_num - i_next_exp;

    always_comb begin
        o_head.seg = w_head;
        if (w_head.seq_num < i_next_exp) begin
            o_head.kind = srsq_pkg::K_STALE;
        end else if (w_dist >= 32'(WINDOW)) begin
            o_head.kind = srsq_pkg::K_BEYOND;
        end else if (w_dist == '0) begin
            o_head.kind = srsq_pkg::K_INORDER;
        end else begin
            o_head.kind = srsq_pkg::K_AHEAD;
        end
    end

    // Slot of the head: expected slot plus distance, wrapped once.
    always_comb begin
        w_sum = {1'b0, i_exp_slot} + {1'b0, w_dist[SLOT_W-1:0]};
        if (w_sum >= WIN_V) begin
            w_sum = w_sum - WIN_V;
        end
        o_head_slot = w_sum[SLOT_W-1:0];
    end

endmodule

FILE: src/srsq_back.sv
`include "segment_resequencer_macros.svh"

module srsq_back #(
    parameter int WINDOW = srsq_pkg::WINDOW_DEF,
    localparam int SLOT_W = $clog2(WINDOW)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  srsq_pkg::t_cmd      i_head,
    input  logic [SLOT_W-1:0]   i_head_slot,
    output logic                o_pop,
    output logic [31:0]         o_next_exp,
    output logic [SLOT_W-1:0]   o_exp_slot,
    output logic                o_strobe,
    output srsq_pkg::t_res      o_res
);

    localparam int CNT_W = srsq_pkg::CNT_W;

    srsq_pkg::t_state  r_state, n_state;
    logic [31:0]       r_next_exp, n_next_exp;
    logic [SLOT_W-1:0] r_exp_slot, n_exp_slot;
    logic [WINDOW-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_strobe, n_strobe;
    srsq_pkg::t_res    r_res, n_res;
    logic [9:0]        r_conn, n_conn;

    logic [SLOT_W-1:0] w_slot_nxt;
    logic              w_valid_nxt;
    logic              w_first_last;
    logic              w_drain_last;
    logic              w_we;
    srsq_pkg::t_slot   w_wdata;
    srsq_pkg::t_slot   w_rdata;
    logic [$bits(srsq_pkg::t_slot)-1:0] w_rdata_raw;

    // Slot after the expected one; the number wraps to zero at 2^32.
    assign w_slot_nxt = (r_next_exp == '1 || r_exp_slot == SLOT_W'(WINDOW - 1))
                      ? '0 : r_exp_slot + SLOT_W'(1);
    assign w_valid_nxt  = r_valid[w_slot_nxt];
    assign w_first_last = !w_valid_nxt || (CNT_W'(1) == CNT_W'(srsq_pkg::MAX_RESULTS));
    assign w_drain_last = !w_valid_nxt
                       || (r_cnt + CNT_W'(1) == CNT_W'(srsq_pkg::MAX_RESULTS));

    assign o_pop      = (r_state == srsq_pkg::ST_IDLE) && i_head_valid;
    assign o_next_exp = r_next_exp;
    assign o_exp_slot = r_exp_slot;
    assign o_strobe   = r_strobe;
    assign o_res      = r_res;

    assign w_wdata.handle = i_head.seg.payload_handle;
    assign w_wdata.len    = i_head.seg.payload_len;
    assign w_rdata        = srsq_pkg::t_slot'(w_rdata_raw);

    srsq_ram #(
        .WIDTH ($bits(srsq_pkg::t_slot)),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_head_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_slot_nxt),
        .o_rdata (w_rdata_raw)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srsq_pkg::ST_IDLE: begin
                if (o_pop && i_head.kind == srsq_pkg::K_INORDER && !w_first_last) begin
                    n_state = srsq_pkg::ST_DRAIN;
                end
            end
            srsq_pkg::ST_DRAIN: begin
                if (w_drain_last) begin
                    n_state = srsq_pkg::ST_IDLE;
                end
            end
            default: n_state = srsq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_next_exp = r_next_exp;
        n_exp_slot = r_exp_slot;
        n_valid    = r_valid;
        n_cnt      = r_cnt;
        n_strobe   = 1'b0;
        n_res      = r_res;
        n_conn     = r_conn;
        w_we       = 1'b0;
        unique case (r_state)
            srsq_pkg::ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_head.kind)
                        srsq_pkg::K_AHEAD: begin
                            w_we                 = 1'b1;
                            n_valid[i_head_slot] = 1'b1;
                        end
                        srsq_pkg::K_BEYOND: begin
                            n_strobe         = 1'b1;
                            n_res.out_conn   = i_head.seg.conn_id;
                            n_res.out_seq    = i_head.seg.seq_num;
                            n_res.out_handle = i_head.seg.payload_handle;
                            n_res.out_len    = i_head.seg.payload_len;
                            n_res.status     = srsq_pkg::ST_REJECTED;
                            n_res.last       = 1'b1;
                        end
                        srsq_pkg::K_INORDER: begin
                            // Deliver the arrival itself; drop any held copy.
                            n_strobe            = 1'b1;
                            n_res.out_conn      = i_head.seg.conn_id;
                            n_res.out_seq       = i_head.seg.seq_num;
                            n_res.out_handle    = i_head.seg.payload_handle;
                            n_res.out_len       = i_head.seg.payload_len;
                            n_res.status        = srsq_pkg::ST_OK;
                            n_res.last          = w_first_last;
                            n_valid[r_exp_slot] = 1'b0;
                            n_next_exp          = r_next_exp + 32'd1;
                            n_exp_slot          = w_slot_nxt;
                            n_conn              = i_head.seg.conn_id;
                            n_cnt               = CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            srsq_pkg::ST_DRAIN: begin
                n_strobe            = 1'b1;
                n_res.out_conn      = r_conn;
                n_res.out_seq       = r_next_exp;
                n_res.out_handle    = w_rdata.handle;
                n_res.out_len       = w_rdata.len;
                n_res.status        = srsq_pkg::ST_OK;
                n_res.last          = w_drain_last;
                n_valid[r_exp_slot] = 1'b0;
                n_next_exp          = r_next_exp + 32'd1;
                n_exp_slot          = w_slot_nxt;
                n_cnt               = r_cnt + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srsq_pkg::ST_IDLE;
            r_next_exp <= '0;
            r_exp_slot <= '0;
            r_valid    <= '0;
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_next_exp <= n_next_exp;
            r_exp_slot <= n_exp_slot;
            r_valid    <= n_valid;
            r_cnt      <= n_cnt;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_conn <= n_conn;
    end

    `SRSQ_ASSERT_NOW(a_drain_slot_held, i_clk, i_rst_n, r_state == srsq_pkg::ST_DRAIN, r_valid[r_exp_slot], "drain reached a slot that is not held")
    `SRSQ_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(srsq_pkg::MAX_RESULTS), "result count beyond limit")
    `SRSQ_ASSERT_NEXT(a_drain_emits, i_clk, i_rst_n, r_state == srsq_pkg::ST_DRAIN, r_strobe && r_res.status == srsq_pkg::ST_OK, "drain cycle gave no delivered result")
    `SRSQ_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, r_strobe && r_res.last, r_state == srsq_pkg::ST_IDLE, "last result while drain still running")
    `SRSQ_ASSERT_NOW(a_more_drains, i_clk, i_rst_n, r_strobe && !r_res.last, r_state == srsq_pkg::ST_DRAIN, "non-final result without a drain to follow")

endmodule

FILE: src/segment_resequencer.sv
// A segment's first result passes through the front queue and the back's result register before it strobes.
// Drained held segments follow one per cycle, up to MAX_RESULTS per segment.
// Back side takes one queued segment per cycle while idle, and none while it drains held segments.
// Front queue of QDEPTH segments; busy is high only while that queue is full.
// Synchronous reset clears next expected number and all slot valid bits.
// Results cannot be stalled: each strobe lasts exactly one cycle.
module segment_resequencer #(
    parameter int WINDOW = srsq_pkg::WINDOW_DEF,
    localparam int SLOT_W = $clog2(WINDOW)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  srsq_pkg::t_seg i_seg,
    output logic           busy,
    output logic           o_strobe,
    output srsq_pkg::t_res o_res
);

    logic              w_head_valid;
    srsq_pkg::t_cmd    w_head;
    logic [SLOT_W-1:0] w_head_slot;
    logic              w_pop;
    logic [31:0]       w_next_exp;
    logic [SLOT_W-1:0] w_exp_slot;

    srsq_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_seg        (i_seg),
        .o_busy       (busy),
        .i_pop        (w_pop),
        .i_next_exp   (w_next_exp),
        .i_exp_slot   (w_exp_slot),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .o_head_slot  (w_head_slot)
    );

    srsq_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .i_head_slot  (w_head_slot),
        .o_pop        (w_pop),
        .o_next_exp   (w_next_exp),
        .o_exp_slot   (w_exp_slot),
        .o_strobe     (o_strobe),
        .o_res        (o_res)
    );

endmodule

FILE: tb/segment_resequencer_tb.sv
module segment_resequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN         = srsq_pkg::WINDOW_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = srsq_pkg::MAX_RESULTS + 16;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    srsq_pkg::t_seg i_seg;
    logic           busy;
    logic           o_strobe;
    srsq_pkg::t_res o_res;

    segment_resequencer #(.WINDOW(WIN)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_seg    (i_seg),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Resequencer state as the testbench sees it
    logic [31:0] next_seq;
    logic        held_valid [WIN];
    logic [15:0] held_handle [WIN];
    logic [13:0] held_len [WIN];

    srsq_pkg::t_res delivery_q[$];

    int fail_cnt        = 0;
    int segs_counted    = 0;
    int stale_cnt       = 0;
    int reject_cnt      = 0;
    int results_checked = 0;
    int deepest_run     = 0;
    int sender_idle_pct = 0;
    int cycle_cnt       = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, delivery_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Work out every result one accepted segment causes and queue them.
    function automatic srsq_pkg::t_kind predict_results(srsq_pkg::t_seg s);
        srsq_pkg::t_res r;
        logic [31:0]    gap;
        int             slot;
        int             n;
        if (s.seq_num < next_seq) begin
            stale_cnt++;
            return srsq_pkg::K_STALE;
        end
        gap = s.seq_num - next_seq;
        r.out_conn = s.conn_id;
        if (gap >= WIN) begin
            r.out_seq    = s.seq_num;
            r.out_handle = s.payload_handle;
            r.out_len    = s.payload_len;
            r.status     = srsq_pkg::ST_REJECTED;
            r.last       = 1'b1;
            delivery_q.insert(delivery_q.size(), r);
            reject_cnt++;
            return srsq_pkg::K_BEYOND;
        end
        slot = int'(s.seq_num % WIN);
        if (gap != 0) begin
            held_valid[slot]  = 1'b1;
            held_handle[slot] = s.payload_handle;
            held_len[slot]    = s.payload_len;
            return srsq_pkg::K_AHEAD;
        end
        r.out_seq    = s.seq_num;
        r.out_handle = s.payload_handle;
        r.out_len    = s.payload_len;
        r.status     = srsq_pkg::ST_OK;
        r.last       = 1'b0;
        delivery_q.insert(delivery_q.size(), r);
        n = 1;
        held_valid[slot] = 1'b0;
        next_seq++;
        // drain the consecutive held segments behind it
        while (n < srsq_pkg::MAX_RESULTS && held_valid[int'(next_seq % WIN)]) begin
            slot = int'(next_seq % WIN);
            r.out_seq    = next_seq;
            r.out_handle = held_handle[slot];
            r.out_len    = held_len[slot];
            delivery_q.insert(delivery_q.size(), r);
            held_valid[slot] = 1'b0;
            next_seq++;
            n++;
        end
        delivery_q[delivery_q.size() - 1].last = 1'b1;
        if (n > deepest_run)
            deepest_run = n;
        return srsq_pkg::K_INORDER;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin : check_results
        srsq_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (delivery_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %p", $time, o_res);
                fail_cnt++;
            end else begin
                want = delivery_q.pop_front();
                results_checked++;
                if (o_res.out_conn !== want.out_conn)
                    report_mismatch("out_conn", 32'(want.out_conn), 32'(o_res.out_conn));
                if (o_res.out_seq !== want.out_seq)
                    report_mismatch("out_seq", want.out_seq, o_res.out_seq);
                if (o_res.out_handle !== want.out_handle)
                    report_mismatch("out_handle", 32'(want.out_handle),
                                    32'(o_res.out_handle));
                if (o_res.out_len !== want.out_len)
                    report_mismatch("out_len", 32'(want.out_len), 32'(o_res.out_len));
                if (o_res.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_res.status));
                if (o_res.last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(o_res.last));
            end
        end
    end

    // Offer one segment and hold it until the block takes it.
    task automatic send_seg(logic [31:0] seq, logic [15:0] handle, logic [13:0] len,
                            logic [9:0] conn);
        srsq_pkg::t_seg  s;
        srsq_pkg::t_kind kind;
        s = '{seq_num: seq, payload_handle: handle, payload_len: len, conn_id: conn};
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_seg <= s;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        kind = predict_results(s);
        if (kind != srsq_pkg::K_STALE)
            segs_counted++;
    endtask

    task automatic send_random(logic [31:0] seq);
        logic [13:0] len;
        len = ($urandom_range(15) == 0) ? 14'($urandom_range(16383))
                                        : 14'($urandom_range(8192));
        send_seg(seq, 16'($urandom), len, 10'($urandom));
    endtask

    task automatic test_in_order();
        send_seg(32'd0, 16'hFFFF, 14'd8192, 10'h3FF);
    endtask

    task automatic test_hold_and_drain();
        send_seg(32'd2, 16'h0000, 14'd0, 10'h000);
        send_seg(32'd3, 16'h1234, 14'd100, 10'h005);
        // duplicate replaces the held copy
        send_seg(32'd3, 16'hABCD, 14'h3FFF, 10'h007);
        send_seg(32'd1, 16'h5555, 14'd1, 10'h000);
    endtask

    task automatic test_stale_and_beyond();
        send_seg(32'd0, 16'h7777, 14'd77, 10'h011);
        send_seg(32'd3, 16'h8888, 14'd88, 10'h022);
        send_seg(32'd4 + WIN, 16'h0F0F, 14'h1555, 10'h155);
        send_seg(32'hFFFF_FFFF, 16'hFFFF, 14'h3FFF, 10'h3FF);
        send_seg(32'h8000_0000, 16'h0000, 14'd0, 10'h000);
    endtask

    task automatic test_window_edge();
        send_seg(32'd4 + WIN - 1, 16'h2AAA, 14'h2AAA, 10'h2AA);
        send_seg(32'd4, 16'hD5D5, 14'h0AAA, 10'h0AA);
        send_seg(32'd4, 16'h1111, 14'd11, 10'h111);
        send_seg(32'd6, 16'h3333, 14'd33, 10'h033);
        send_seg(32'd5, 16'h4444, 14'd44, 10'h044);
    endtask

    // Mostly shuffled runs of consecutive numbers, with stale, far-ahead and lone holds mixed in.
    task automatic run_random(int target, int idle_pct);
        int          first_cnt;
        int          pick;
        int          burst;
        int          j;
        logic [31:0] base;
        logic [31:0] tmp;
        logic [31:0] order[$];
        sender_idle_pct = idle_pct;
        first_cnt = segs_counted + stale_cnt;
        while (segs_counted + stale_cnt - first_cnt < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                burst = ($urandom_range(9) == 0) ? $urandom_range(WIN, 32)
                                                 : $urandom_range(8, 1);
                base = next_seq;
                order.delete();
                for (int k = 0; k < burst; k++)
                    order.insert(order.size(), base + k);
                for (int k = burst - 1; k > 0; k--) begin
                    j = $urandom_range(k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                if ($urandom_range(3) == 0)
                    order.insert($urandom_range(order.size()),
                                 order[$urandom_range(order.size() - 1)]);
                for (int k = 0; k < order.size(); k++)
                    send_random(order[k]);
            end else if (pick < 85) begin
                if (next_seq != 0)
                    send_random($urandom_range(next_seq - 1));
                else
                    send_random(next_seq + WIN + $urandom_range(255));
            end else if (pick < 95) begin
                if ($urandom_range(1) == 0)
                    send_random($urandom);
                else
                    send_random(next_seq + WIN + $urandom_range(255));
            end else begin
                send_random(next_seq + $urandom_range(WIN - 1, 1));
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_seg   <= '0;
        next_seq = '0;
        for (int k = 0; k < WIN; k++)
            held_valid[k] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_in_order();
        test_hold_and_drain();
        test_stale_and_beyond();
        test_window_edge();

        run_random(130, 18);
        run_random(130, 59);
        run_random(140, 0);

        start <= 1'b0;
        while (delivery_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d segments plus %0d stale ones; checked %0d results, %0d rejected",
                 segs_counted, stale_cnt, results_checked, reject_cnt);
        $display("Longest in-order run %0d, next expected number %0d", deepest_run, next_seq);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
